// ===== sv/tss_pkg.sv =====
package tss_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_MUL_H,
    ST_DIFF,
    ST_SQRT,
    ST_MUL_G,
    ST_DIV_G,
    ST_WAIT_G,
    ST_MUL_A,
    ST_MUL_T,
    ST_DIV_A,
    ST_WAIT_A,
    ST_FIN
  } state_e;

  localparam int DivNumW  = 33;
  localparam int DivDenW  = 28;
  localparam int SqrtSteps = 28;

  localparam logic [17:0] DaySeconds = 18'd86400;
  localparam logic [32:0] GradLimit  = 33'd1000000;
  localparam logic [23:0] GradScale  = 24'd160000;
  localparam logic [23:0] AccScale   = 24'd1000;
  localparam logic [23:0] AccDiv     = 24'd36;

endpackage

// ===== sv/tss_div.sv =====
module tss_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tss_pkg::DivNumW-1:0]     num_i,
  input  logic [tss_pkg::DivDenW-1:0]     den_i,
  output logic                            done_o,
  output logic [tss_pkg::DivNumW-1:0]     quo_o
);

  localparam int NW = tss_pkg::DivNumW;
  localparam int DW = tss_pkg::DivDenW;
  localparam int CW = $clog2(NW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] rem_q;
  logic [NW-1:0] quo_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= DW'(trial - {1'b0, den_q});
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/trip_segment_statistics.sv =====
// a first row of a track goes straight to the finish state; other rows take two products and a
// difference, where needed 28 square-root steps, a product and a 33-step division, then
// two products and where needed a 33-step division; the input stalls while a word is in work
// the square root runs one result bit per cycle, the shared divider one quotient bit per cycle
// reset: asynchronous, active low; history and totals clear, the next row counts as first
module trip_segment_statistics (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               new_track_i,
  input  logic [19:0]        odometer_dam_i,
  input  logic signed [14:0] height_m_i,
  input  logic [11:0]        speed_dkmh_i,
  input  logic [7:0]         heart_rate_i,
  input  logic signed [6:0]  temp_whole_i,
  input  logic [3:0]         temp_tenth_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [23:0]        total_distance_m_o,
  output logic signed [24:0] segment_distance_m_o,
  output logic signed [15:0] height_delta_m_o,
  output logic [27:0]        flat_distance_q4_o,
  output logic signed [20:0] gradient_cpct_o,
  output logic [16:0]        elapsed_s_o,
  output logic signed [17:0] accel_mm_s2_o,
  output logic [31:0]        total_time_s_o,
  output logic [31:0]        moving_time_s_o,
  output logic [23:0]        total_up_m_o,
  output logic [23:0]        total_down_m_o,
  output logic signed [10:0] temperature_dc_o
);

  tss_pkg::state_e state_q, state_d;

  logic        accept;
  logic        out_free;
  logic        first_pending_q;
  logic [23:0] prev_dist_q;
  logic [14:0] prev_height_q;
  logic [11:0] prev_speed_q;
  logic [16:0] prev_time_q;
  logic [31:0] time_sum_q;
  logic [31:0] moving_sum_q;
  logic [23:0] up_sum_q;
  logic [23:0] down_sum_q;

  logic               first_q;
  logic [23:0]        dist_q;
  logic signed [24:0] d_q;
  logic signed [15:0] h_q;
  logic [16:0]        el_q;
  logic signed [12:0] dv_q;
  logic               moving_q;
  logic signed [10:0] temp_q;
  logic [47:0]        prod_q;
  logic [47:0]        dd_q;
  logic [55:0]        rad_q;
  logic [27:0]        root_q;
  logic [29:0]        srem_q;
  logic [4:0]         cnt_q;
  logic [21:0]        acc_num_q;
  logic [20:0]        grad_q;
  logic [17:0]        acc_q;

  // word fields at acceptance
  logic [23:0]        dist_w;
  logic signed [24:0] d_w;
  logic signed [15:0] h_w;
  logic [16:0]        t_w;
  logic signed [17:0] el_raw;
  logic signed [17:0] el_wrap;
  logic [16:0]        el_w;
  logic signed [12:0] dv_w;
  logic signed [10:0] tw10;
  logic signed [10:0] temp_w;
  logic               first_w;

  assign first_w = new_track_i | first_pending_q;
  assign dist_w  = 24'({odometer_dam_i, 3'b000}) + 24'({odometer_dam_i, 1'b0});
  assign d_w     = $signed({1'b0, dist_w}) - $signed({1'b0, prev_dist_q});
  assign h_w     = $signed({height_m_i[14], height_m_i})
                 - $signed({prev_height_q[14], prev_height_q});
  assign t_w     = 17'(hour_i) * 17'd3600 + 17'(minute_i) * 17'd60 + 17'(second_i);
  assign el_raw  = $signed({1'b0, t_w}) - $signed({1'b0, prev_time_q});
  assign el_wrap = el_raw + $signed(tss_pkg::DaySeconds);
  always_comb begin
    if (el_raw >= 0) begin
      el_w = el_raw[16:0];
    end else if (el_wrap >= 0) begin
      el_w = el_wrap[16:0];
    end else begin
      el_w = '0;
    end
  end
  assign dv_w   = $signed({1'b0, speed_dkmh_i}) - $signed({1'b0, prev_speed_q});
  assign tw10   = $signed({{4{temp_whole_i[6]}}, temp_whole_i}) * 11'sd10;
  assign temp_w = temp_whole_i[6] ? tw10 - $signed(11'(temp_tenth_i))
                                  : tw10 + $signed(11'(temp_tenth_i));

  // magnitudes and the shared multiplier
  logic [24:0] d_neg;
  logic [15:0] h_neg;
  logic [12:0] dv_neg;
  logic [23:0] d_mag;
  logic [23:0] h_mag;
  logic [23:0] dv_mag;
  logic [23:0] mul_a;
  logic [23:0] mul_b;
  logic [47:0] prod_w;

  assign d_neg  = -d_q;
  assign h_neg  = -h_q;
  assign dv_neg = -dv_q;
  assign d_mag  = d_q[24] ? d_neg[23:0] : d_q[23:0];
  assign h_mag  = 24'(h_q[15] ? h_neg : h_q);
  assign dv_mag = 24'(dv_q[12] ? dv_neg : dv_q);
  assign prod_w = mul_a * mul_b;

  // square-root step
  logic signed [48:0] sq_w;
  logic [31:0]        rem2;
  logic [31:0]        strial;

  assign sq_w   = $signed({1'b0, dd_q}) - $signed({1'b0, prod_q});
  assign rem2   = {srem_q, rad_q[55:54]};
  assign strial = {2'b00, root_q, 2'b01};

  // divider
  logic                           div_start;
  logic [tss_pkg::DivNumW-1:0]    div_num;
  logic [tss_pkg::DivDenW-1:0]    div_den;
  logic                           div_done;
  logic [tss_pkg::DivNumW-1:0]    div_quo;
  logic [32:0]                    grad_mag;
  logic [20:0]                    grad_neg;
  logic [17:0]                    acc_neg;

  tss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign grad_mag = (div_quo > tss_pkg::GradLimit) ? tss_pkg::GradLimit : div_quo;
  assign grad_neg = -grad_mag[20:0];
  assign acc_neg  = -div_quo[17:0];

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != tss_pkg::ST_IDLE);
  assign out_free   = ~out_valid_o | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    mul_a     = d_mag;
    mul_b     = d_mag;
    div_start = 1'b0;
    div_num   = prod_q[32:0];
    div_den   = root_q;
    case (state_q)
      tss_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = first_w ? tss_pkg::ST_FIN : tss_pkg::ST_MUL_D;
        end
      end
      tss_pkg::ST_MUL_D: state_d = tss_pkg::ST_MUL_H;
      tss_pkg::ST_MUL_H: begin
        mul_a   = h_mag;
        mul_b   = h_mag;
        state_d = tss_pkg::ST_DIFF;
      end
      tss_pkg::ST_DIFF: begin
        state_d = (sq_w > 0) ? tss_pkg::ST_SQRT : tss_pkg::ST_MUL_A;
      end
      tss_pkg::ST_SQRT: begin
        if (cnt_q == 5'd0) begin
          state_d = tss_pkg::ST_MUL_G;
        end
      end
      tss_pkg::ST_MUL_G: begin
        mul_a   = h_mag;
        mul_b   = tss_pkg::GradScale;
        state_d = (root_q != '0) ? tss_pkg::ST_DIV_G : tss_pkg::ST_MUL_A;
      end
      tss_pkg::ST_DIV_G: begin
        div_start = 1'b1;
        state_d   = tss_pkg::ST_WAIT_G;
      end
      tss_pkg::ST_WAIT_G: begin
        if (div_done) begin
          state_d = tss_pkg::ST_MUL_A;
        end
      end
      tss_pkg::ST_MUL_A: begin
        mul_a   = dv_mag;
        mul_b   = tss_pkg::AccScale;
        state_d = tss_pkg::ST_MUL_T;
      end
      tss_pkg::ST_MUL_T: begin
        mul_a   = 24'(el_q);
        mul_b   = tss_pkg::AccDiv;
        state_d = (el_q != '0) ? tss_pkg::ST_DIV_A : tss_pkg::ST_FIN;
      end
      tss_pkg::ST_DIV_A: begin
        div_start = 1'b1;
        div_num   = 33'(acc_num_q);
        div_den   = prod_q[27:0];
        state_d   = tss_pkg::ST_WAIT_A;
      end
      tss_pkg::ST_WAIT_A: begin
        if (div_done) begin
          state_d = tss_pkg::ST_FIN;
        end
      end
      tss_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = tss_pkg::ST_IDLE;
        end
      end
      default: state_d = tss_pkg::ST_IDLE;
    endcase
  end

  // history, totals and output valid
  logic [32:0] time_add;
  logic [32:0] moving_add;
  logic [24:0] up_add;
  logic [24:0] down_add;

  assign time_add   = {1'b0, time_sum_q} + 33'(el_q);
  assign moving_add = {1'b0, moving_sum_q} + 33'(el_q);
  assign up_add     = {1'b0, up_sum_q} + 25'(h_mag);
  assign down_add   = {1'b0, down_sum_q} + 25'(h_mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_pending_q <= 1'b1;
      prev_dist_q     <= '0;
      prev_height_q   <= '0;
      prev_speed_q    <= '0;
      prev_time_q     <= '0;
      time_sum_q      <= '0;
      moving_sum_q    <= '0;
      up_sum_q        <= '0;
      down_sum_q      <= '0;
      out_valid_o     <= 1'b0;
    end else begin
      if (accept) begin
        first_pending_q <= 1'b0;
        prev_dist_q     <= dist_w;
        prev_height_q   <= height_m_i;
        prev_speed_q    <= speed_dkmh_i;
        prev_time_q     <= t_w;
      end
      if (state_q == tss_pkg::ST_FIN && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (state_q == tss_pkg::ST_FIN && out_free) begin
        if (first_q) begin
          time_sum_q   <= '0;
          moving_sum_q <= '0;
          up_sum_q     <= '0;
          down_sum_q   <= '0;
        end else begin
          time_sum_q <= time_add[32] ? '1 : time_add[31:0];
          if (moving_q) begin
            moving_sum_q <= moving_add[32] ? '1 : moving_add[31:0];
          end
          if (h_q > 0) begin
            up_sum_q <= up_add[24] ? '1 : up_add[23:0];
          end else begin
            down_sum_q <= down_add[24] ? '1 : down_add[23:0];
          end
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_q  <= first_w;
      dist_q   <= dist_w;
      d_q      <= first_w ? '0 : d_w;
      h_q      <= first_w ? '0 : h_w;
      el_q     <= first_w ? '0 : el_w;
      dv_q     <= dv_w;
      moving_q <= (speed_dkmh_i != '0);
      temp_q   <= temp_w;
      root_q   <= '0;
      grad_q   <= '0;
      acc_q    <= '0;
    end
    case (state_q)
      tss_pkg::ST_MUL_D: prod_q <= prod_w;
      tss_pkg::ST_MUL_H: begin
        dd_q   <= prod_q;
        prod_q <= prod_w;
      end
      tss_pkg::ST_DIFF: begin
        rad_q  <= {sq_w[47:0], 8'h00};
        root_q <= '0;
        srem_q <= '0;
        cnt_q  <= 5'(tss_pkg::SqrtSteps - 1);
      end
      tss_pkg::ST_SQRT: begin
        rad_q <= {rad_q[53:0], 2'b00};
        cnt_q <= cnt_q - 1'b1;
        if (rem2 >= strial) begin
          srem_q <= 30'(rem2 - strial);
          root_q <= {root_q[26:0], 1'b1};
        end else begin
          srem_q <= rem2[29:0];
          root_q <= {root_q[26:0], 1'b0};
        end
      end
      tss_pkg::ST_MUL_G: prod_q <= prod_w;
      tss_pkg::ST_WAIT_G: begin
        if (div_done) begin
          grad_q <= h_q[15] ? grad_neg : grad_mag[20:0];
        end
      end
      tss_pkg::ST_MUL_A: prod_q <= prod_w;
      tss_pkg::ST_MUL_T: begin
        acc_num_q <= prod_q[21:0];
        prod_q    <= prod_w;
      end
      tss_pkg::ST_WAIT_A: begin
        if (div_done) begin
          acc_q <= dv_q[12] ? acc_neg : div_quo[17:0];
        end
      end
      default: ;
    endcase
    if (state_q == tss_pkg::ST_FIN && out_free) begin
      total_distance_m_o   <= dist_q;
      segment_distance_m_o <= d_q;
      height_delta_m_o     <= h_q;
      flat_distance_q4_o   <= root_q;
      gradient_cpct_o      <= $signed(grad_q);
      elapsed_s_o          <= el_q;
      accel_mm_s2_o        <= $signed(acc_q);
      temperature_dc_o     <= temp_q;
      total_time_s_o       <= first_q ? '0 : (time_add[32] ? '1 : time_add[31:0]);
      moving_time_s_o      <= (first_q) ? '0 :
                              (!moving_q ? moving_sum_q :
                               (moving_add[32] ? '1 : moving_add[31:0]));
      total_up_m_o         <= (first_q) ? '0 :
                              (!(h_q > 0) ? up_sum_q :
                               (up_add[24] ? '1 : up_add[23:0]));
      total_down_m_o       <= (first_q) ? '0 :
                              ((h_q > 0) ? down_sum_q :
                               (down_add[24] ? '1 : down_add[23:0]));
    end
  end

  logic unused_hr;
  assign unused_hr = ^heart_rate_i;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("accepted word did not make the block busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == tss_pkg::ST_WAIT_G || state_q == tss_pkg::ST_WAIT_A))
    else $error("divider finished outside a wait state");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tss_pkg::ST_FIN && out_free) |=> out_valid_o)
    else $error("finished word not presented");

  a_first_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_pending_q |-> (time_sum_q == '0 && up_sum_q == '0))
    else $error("totals not clear before first row");

endmodule

// ===== tb/trip_checker.sv =====
`timescale 1ns / 100ps

module trip_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               new_track_i,
  input  logic [19:0]        odometer_dam_i,
  input  logic signed [14:0] height_m_i,
  input  logic [11:0]        speed_dkmh_i,
  input  logic signed [6:0]  temp_whole_i,
  input  logic [3:0]         temp_tenth_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [23:0]        total_distance_m_i,
  input  logic signed [24:0] segment_distance_m_i,
  input  logic signed [15:0] height_delta_m_i,
  input  logic [27:0]        flat_distance_q4_i,
  input  logic signed [20:0] gradient_cpct_i,
  input  logic [16:0]        elapsed_s_i,
  input  logic signed [17:0] accel_mm_s2_i,
  input  logic [31:0]        total_time_s_i,
  input  logic [31:0]        moving_time_s_i,
  input  logic [23:0]        total_up_m_i,
  input  logic [23:0]        total_down_m_i,
  input  logic signed [10:0] temperature_dc_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 segments_o
);

  typedef struct packed {
    logic [23:0]        tdist;
    logic signed [24:0] seg;
    logic signed [15:0] dh;
    logic [27:0]        flat;
    logic signed [20:0] grad;
    logic [16:0]        el;
    logic signed [17:0] acc;
    logic [31:0]        tsum;
    logic [31:0]        msum;
    logic [23:0]        up;
    logic [23:0]        down;
    logic signed [10:0] temp;
  } segment_t;

  segment_t segment_q[$];

  logic        fresh;
  logic [23:0] last_dist;
  logic signed [14:0] last_height;
  logic [11:0] last_speed;
  logic [16:0] last_tod;
  logic [31:0] sum_time, sum_moving;
  logic [23:0] sum_up, sum_down;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, longint b, longint unsigned mx);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > mx) ? mx[31:0] : s[31:0];
  endfunction

  task automatic predict_segment();
    segment_t e;
    longint dist_m, d, h, sq, g, el, a, tod, spd;
    longint unsigned fl;
    e = '0;
    dist_m = longint'(odometer_dam_i) * 10;
    spd = longint'(speed_dkmh_i);
    tod = longint'(hour_i) * 3600 + longint'(minute_i) * 60 + longint'(second_i);
    e.tdist = dist_m[23:0];
    if (temp_whole_i >= 0) e.temp = 11'(int'(temp_whole_i) * 10 + int'(temp_tenth_i));
    else e.temp = 11'(int'(temp_whole_i) * 10 - int'(temp_tenth_i));
    if (new_track_i || fresh) begin
      fresh = 1'b0;
      sum_time = 0;
      sum_moving = 0;
      sum_up = 0;
      sum_down = 0;
    end else begin
      d = dist_m - longint'(last_dist);
      h = longint'(height_m_i) - longint'(last_height);
      sq = d * d - h * h;
      fl = 0;
      g = 0;
      a = 0;
      if (sq > 0) fl = root_floor(longint'(sq) * 256);
      if (fl != 0) begin
        g = (h * 160000) / longint'(fl);
        if (g > 1000000) g = 1000000;
        if (g < -1000000) g = -1000000;
      end
      el = tod - longint'(last_tod);
      if (el < 0) el += 86400;
      if (el < 0) el = 0;
      sum_time = sat_sum(sum_time, el, 64'hFFFF_FFFF);
      if (speed_dkmh_i != 0) sum_moving = sat_sum(sum_moving, el, 64'hFFFF_FFFF);
      if (el != 0) a = ((spd - longint'(last_speed)) * 1000) / (36 * el);
      if (h > 0) sum_up = 24'(sat_sum({8'd0, sum_up}, h, 64'hFF_FFFF));
      else sum_down = 24'(sat_sum({8'd0, sum_down}, -h, 64'hFF_FFFF));
      e.seg = d[24:0];
      e.dh = h[15:0];
      e.flat = fl[27:0];
      e.grad = g[20:0];
      e.el = el[16:0];
      e.acc = a[17:0];
      segments_o++;
    end
    e.tsum = sum_time;
    e.msum = sum_moving;
    e.up = sum_up;
    e.down = sum_down;
    last_dist = dist_m[23:0];
    last_height = height_m_i;
    last_speed = speed_dkmh_i;
    last_tod = tod[16:0];
    segment_q.push_back(e);
  endtask

  task automatic compare_segment();
    segment_t e;
    if (segment_q.size() == 0) begin
      $error("result word with no expectation");
      errors_o++;
      return;
    end
    e = segment_q.pop_front();
    if (total_distance_m_i !== e.tdist) begin
      $error("total_distance_m exp %0d got %0d", e.tdist, total_distance_m_i); errors_o++;
    end
    if (segment_distance_m_i !== e.seg) begin
      $error("segment_distance_m exp %0d got %0d", e.seg, segment_distance_m_i); errors_o++;
    end
    if (height_delta_m_i !== e.dh) begin
      $error("height_delta_m exp %0d got %0d", e.dh, height_delta_m_i); errors_o++;
    end
    if (flat_distance_q4_i !== e.flat) begin
      $error("flat_distance_q4 exp %0d got %0d", e.flat, flat_distance_q4_i); errors_o++;
    end
    if (gradient_cpct_i !== e.grad) begin
      $error("gradient_cpct exp %0d got %0d", e.grad, gradient_cpct_i); errors_o++;
    end
    if (elapsed_s_i !== e.el) begin
      $error("elapsed_s exp %0d got %0d", e.el, elapsed_s_i); errors_o++;
    end
    if (accel_mm_s2_i !== e.acc) begin
      $error("accel_mm_s2 exp %0d got %0d", e.acc, accel_mm_s2_i); errors_o++;
    end
    if (total_time_s_i !== e.tsum) begin
      $error("total_time_s exp %0d got %0d", e.tsum, total_time_s_i); errors_o++;
    end
    if (moving_time_s_i !== e.msum) begin
      $error("moving_time_s exp %0d got %0d", e.msum, moving_time_s_i); errors_o++;
    end
    if (total_up_m_i !== e.up) begin
      $error("total_up_m exp %0d got %0d", e.up, total_up_m_i); errors_o++;
    end
    if (total_down_m_i !== e.down) begin
      $error("total_down_m exp %0d got %0d", e.down, total_down_m_i); errors_o++;
    end
    if (temperature_dc_i !== e.temp) begin
      $error("temperature_dc exp %0d got %0d", e.temp, temperature_dc_i); errors_o++;
    end
  endtask

  initial begin
    errors_o = 0;
    segments_o = 0;
    fresh = 1'b1;
    last_dist = '0;
    last_height = '0;
    last_speed = '0;
    last_tod = '0;
    sum_time = '0;
    sum_moving = '0;
    sum_up = '0;
    sum_down = '0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) compare_segment();
      if (in_valid_i && !in_stall_i) predict_segment();
    end
  end

  assign pending_o = segment_q.size();

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               new_track_i = 1'b0;
  logic [19:0]        odometer_dam_i = '0;
  logic signed [14:0] height_m_i = '0;
  logic [11:0]        speed_dkmh_i = '0;
  logic [7:0]         heart_rate_i = '0;
  logic signed [6:0]  temp_whole_i = '0;
  logic [3:0]         temp_tenth_i = '0;
  logic [4:0]         hour_i = '0;
  logic [5:0]         minute_i = '0;
  logic [5:0]         second_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [23:0]        total_distance_m_o;
  logic signed [24:0] segment_distance_m_o;
  logic signed [15:0] height_delta_m_o;
  logic [27:0]        flat_distance_q4_o;
  logic signed [20:0] gradient_cpct_o;
  logic [16:0]        elapsed_s_o;
  logic signed [17:0] accel_mm_s2_o;
  logic [31:0]        total_time_s_o;
  logic [31:0]        moving_time_s_o;
  logic [23:0]        total_up_m_o;
  logic [23:0]        total_down_m_o;
  logic signed [10:0] temperature_dc_o;

  int errors, pending, segments;
  int idle_cycles = 0;
  int rows_sent;
  logic quiet;

  localparam int WatchdogLimit = 20000;

  trip_segment_statistics dut (.*);

  trip_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .new_track_i,
    .odometer_dam_i, .height_m_i, .speed_dkmh_i, .temp_whole_i, .temp_tenth_i,
    .hour_i, .minute_i, .second_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .total_distance_m_i(total_distance_m_o), .segment_distance_m_i(segment_distance_m_o),
    .height_delta_m_i(height_delta_m_o), .flat_distance_q4_i(flat_distance_q4_o),
    .gradient_cpct_i(gradient_cpct_o), .elapsed_s_i(elapsed_s_o),
    .accel_mm_s2_i(accel_mm_s2_o), .total_time_s_i(total_time_s_o),
    .moving_time_s_i(moving_time_s_o), .total_up_m_i(total_up_m_o),
    .total_down_m_i(total_down_m_o), .temperature_dc_i(temperature_dc_o),
    .errors_o(errors), .pending_o(pending), .segments_o(segments)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      n = gap_len();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // watchdog on acceptance
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_row(logic nt, logic [19:0] odo, logic signed [14:0] hgt,
                          logic [11:0] spd, logic signed [6:0] tw, logic [3:0] tt,
                          logic [4:0] hh, logic [5:0] mm, logic [5:0] ss);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    new_track_i    <= nt;
    odometer_dam_i <= odo;
    height_m_i     <= hgt;
    speed_dkmh_i   <= spd;
    heart_rate_i   <= 8'($urandom);
    temp_whole_i   <= tw;
    temp_tenth_i   <= tt;
    hour_i         <= hh;
    minute_i       <= mm;
    second_i       <= ss;
    do @(posedge clk_i); while (in_stall_o);
    rows_sent++;
  endtask

  task automatic send_noise(logic nt);
    send_row(nt, 20'($urandom), 15'($urandom), 12'($urandom), 7'($urandom),
             4'($urandom), 5'($urandom), 6'($urandom), 6'($urandom));
  endtask

  initial begin
    int odo, hgt, tod, len;
    quiet = 1'b0;
    rows_sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, wraps, saturation-free corners
    send_row(1'b0, 20'd0, 15'sd0, 12'd0, 7'sd0, 4'd0, 5'd0, 6'd0, 6'd0);
    send_row(1'b0, 20'd999999, 15'sd16383, 12'd4095, 7'sd63, 4'd9, 5'd23, 6'd59, 6'd59);
    send_row(1'b0, 20'd0, -15'sd2048, 12'd0, -7'sd64, 4'd9, 5'd0, 6'd0, 6'd1);
    send_row(1'b0, 20'd0, -15'sd2048, 12'd1, 7'sd0, 4'd5, 5'd0, 6'd0, 6'd1);
    send_row(1'b0, 20'd1, 15'sd100, 12'd4095, -7'sd1, 4'd0, 5'd0, 6'd0, 6'd2);
    send_row(1'b0, 20'd2, 15'sd100, 12'd0, 7'sd1, 4'd15, 5'd31, 6'd63, 6'd63);
    send_row(1'b0, 20'd3, 15'sd90, 12'd10, 7'sd0, 4'd0, 5'd0, 6'd0, 6'd0);
    send_row(1'b0, 20'hFFFFF, 15'sd16383, 12'd20, -7'sd64, 4'd15, 5'd31, 6'd63, 6'd63);
    send_row(1'b0, 20'd0, 15'h4000, 12'd0, 7'sd63, 4'd15, 5'd0, 6'd0, 6'd0);
    send_row(1'b1, 20'd500, 15'sd0, 12'd50, 7'sd20, 4'd3, 5'd12, 6'd0, 6'd0);
    send_row(1'b0, 20'd501, 15'sd3, 12'd60, 7'sd20, 4'd3, 5'd12, 6'd0, 6'd30);
    send_row(1'b0, 20'd502, -15'sd10, 12'd40, 7'sd20, 4'd3, 5'd12, 6'd1, 6'd0);
    send_row(1'b0, 20'd502, -15'sd10, 12'd0, 7'sd20, 4'd3, 5'd12, 6'd1, 6'd0);
    send_row(1'b0, 20'd510, 15'sd16383, 12'd0, 7'sd20, 4'd3, 5'd12, 6'd2, 6'd0);
    send_row(1'b0, 20'hAAAAA, 15'h5555, 12'hAAA, 7'h55, 4'hA, 5'h15, 6'h2A, 6'h15);
    send_row(1'b0, 20'h55555, 15'h2AAA, 12'h555, 7'h2A, 4'h5, 5'h0A, 6'h15, 6'h2A);

    // random tracks of plausible rows with some noise
    while (rows_sent < 830) begin
      len = $urandom_range(3, 40);
      odo = $urandom_range(0, 990000);
      hgt = $urandom_range(0, 3000) - 500;
      tod = $urandom_range(0, 86399);
      quiet = ($urandom_range(0, 4) == 0);
      send_row(1'b1, 20'(odo), 15'(hgt), 12'($urandom_range(0, 4095)),
               7'(int'($urandom_range(0, 127)) - 64),
               4'($urandom_range(0, 9)), 5'(tod / 3600), 6'((tod / 60) % 60), 6'(tod % 60));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_noise(1'($urandom_range(0, 1)));
        end else begin
          odo = (odo + $urandom_range(0, 60)) % 1000000;
          hgt = hgt + int'($urandom_range(0, 80)) - 40;
          if (hgt > 16383) hgt = 16383;
          if (hgt < -2048) hgt = -2048;
          tod = (tod + $urandom_range(0, 120)) % 86400;
          send_row(1'b0, 20'(odo), 15'(hgt),
                   ($urandom_range(0, 5) == 0) ? 12'd0 : 12'($urandom_range(0, 4095)),
                   7'(int'($urandom_range(0, 127)) - 64), 4'($urandom_range(0, 9)),
                   5'(tod / 3600), 6'((tod / 60) % 60), 6'(tod % 60));
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("rows sent: %0d, segment rows checked: %0d", rows_sent, segments);
    $display("covered track starts, time wrap, extremes and random tracks");
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
